// ----- design/msrs_pkg.sv -----
`timescale 1ns / 1ps
package msrs_pkg;

	localparam int ECHO_W = 4;
	localparam int CNT_W = 16;
	localparam int DIST_W = 11;
	localparam int WHO_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// floor(x / 58) for 16-bit x as (x * ceil(2^23 / 58)) >> 23
	localparam int DIV_SHIFT = 23;
	localparam int DIV_MUL_W = 18;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL = 18'd144632;
	localparam int PROD_W = CNT_W + DIV_MUL_W;

	localparam logic [CNT_W-1:0] TRIGGER_RST = 16'd20;
	localparam logic [CNT_W-1:0] COOLDOWN_RST = 16'd20000;
	localparam logic [DIST_W-1:0] NEAR_RST = 11'd10;

	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR = 2'd2;

	typedef enum logic [1:0] {
		PH_TRIGGER,
		PH_WAIT,
		PH_MEASURE,
		PH_COOLDOWN
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0] trigger_ticks;
		logic [CNT_W-1:0] cooldown_ticks;
		logic [DIST_W-1:0] near_threshold_cm;
	} cfg_t;

	typedef struct packed {
		logic near_flag;
		logic [DIST_W-1:0] distance_cm;
		logic [WHO_W-1:0] measured_sensor;
		logic result_valid;
		logic [ECHO_W-1:0] trigger_pins;
	} res_t;

	function automatic logic [DIST_W-1:0] div58(input logic [CNT_W-1:0] x);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(x) * PROD_W'(DIV_MUL);
		return prod[PROD_W-1:DIV_SHIFT];
	endfunction

endpackage

// ----- design/msrs_seq.sv -----
`timescale 1ns / 1ps
module msrs_seq #(
	parameter int SENSOR_COUNT = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic [msrs_pkg::ECHO_W-1:0] echo_levels,
	input  msrs_pkg::cfg_t cfg,
	output msrs_pkg::res_t res
);
	import msrs_pkg::*;

	localparam int SW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam logic [SW-1:0] LAST_SENSOR = SW'(SENSOR_COUNT - 1);

	phase_t phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [SW-1:0] sensor_q, sensor_d;
	logic near_q, near_d;

	logic [2:0] sensor_ext;
	logic in_range;
	logic level;
	logic [CNT_W-1:0] cnt_sat;
	logic [DIST_W-1:0] dist_cm;

	assign sensor_ext = 3'(sensor_q);
	assign in_range = !sensor_ext[2];
	assign level = in_range && echo_levels[sensor_ext[1:0]];
	assign cnt_sat = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign dist_cm = div58(cnt_q);

	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		sensor_d = sensor_q;
		near_d = near_q;
		unique case (phase_q)
			PH_TRIGGER: begin
				cnt_d = cnt_sat;
				if (cnt_sat >= cfg.trigger_ticks) begin
					phase_d = PH_WAIT;
					cnt_d = '0;
				end
			end
			PH_WAIT: begin
				if (level) begin
					phase_d = PH_MEASURE;
					cnt_d = CNT_W'(1);
				end
			end
			PH_MEASURE: begin
				if (level) begin
					cnt_d = cnt_sat;
				end else begin
					near_d = (dist_cm <= cfg.near_threshold_cm);
					phase_d = PH_COOLDOWN;
					cnt_d = '0;
				end
			end
			PH_COOLDOWN: begin
				cnt_d = cnt_sat;
				if (cnt_sat >= cfg.cooldown_ticks) begin
					phase_d = PH_TRIGGER;
					cnt_d = '0;
					sensor_d = (sensor_q == LAST_SENSOR) ? '0 : sensor_q + 1'b1;
				end
			end
			default: begin
				phase_d = PH_TRIGGER;
			end
		endcase
	end

	always_comb begin
		res = '0;
		res.near_flag = near_d;
		unique case (phase_q)
			PH_TRIGGER: begin
				res.trigger_pins = in_range ? (ECHO_W'(1) << sensor_ext[1:0]) : '0;
			end
			PH_MEASURE: begin
				if (!level) begin
					res.result_valid = 1'b1;
					res.measured_sensor = sensor_ext[1:0];
					res.distance_cm = dist_cm;
				end
			end
			default: begin
				res.trigger_pins = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TRIGGER;
			cnt_q <= '0;
			sensor_q <= '0;
			near_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			sensor_q <= sensor_d;
			near_q <= near_d;
		end
	end

endmodule

// ----- design/multi_sonar_range_scanner_core.sv -----
`timescale 1ns / 1ps
// Round-robin ultrasonic ranging controller. Every input transfer is one timer tick carrying
// the echo levels of all sensors, and every tick yields exactly one output transfer with the
// trigger drive for that tick, plus a measurement when the current sensor's echo falls
// (distance = echo ticks / 58, counted with saturation at 65535) and the held near flag.
// One tick is accepted every clock while the output is not stalled. Each tick is held in the
// input register, passes the one-pass sequencer, and is held in the output register, from
// which it is offered on the output channel as a single transfer.
// Configuration is taken on the cfg channel at any time (always ready) but must only be
// changed while no tick is in flight. After reset: trigger 20, cooldown 20000, near 10 cm.
module multi_sonar_range_scanner_core #(
	parameter int SENSOR_COUNT = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [3:0] echo_levels
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,  // [3:0] trigger_pins, [5:4] measured_sensor,
	                              // [16:6] distance_cm, [17] near_flag
	output logic m_tuser,         // [0] result_valid
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [msrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msrs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import msrs_pkg::*;

	cfg_t cfg_q;
	logic valid_s1;
	logic [ECHO_W-1:0] echo_s1;
	logic m_tvalid_q;
	res_t res_q;
	res_t res;
	logic move_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks <= TRIGGER_RST;
			cfg_q.cooldown_ticks <= COOLDOWN_RST;
			cfg_q.near_threshold_cm <= NEAR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TRIGGER: begin
					cfg_q.trigger_ticks <= cfg_data;
				end
				REG_COOLDOWN: begin
					cfg_q.cooldown_ticks <= cfg_data;
				end
				REG_NEAR: begin
					cfg_q.near_threshold_cm <= cfg_data[DIST_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign move_s1 = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (move_s1) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			echo_s1 <= s_tdata[ECHO_W-1:0];
		end
		if (move_s1) begin
			res_q <= res;
		end
	end

	msrs_seq #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.advance(move_s1),
		.echo_levels(echo_s1),
		.cfg(cfg_q),
		.res(res)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser = res_q.result_valid;
	assign m_tdata = {6'd0, res_q.near_flag, res_q.distance_cm, res_q.measured_sensor,
		res_q.trigger_pins};

	a_pins_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> $onehot0(res_q.trigger_pins))
		else $error("more than one trigger pin driven");

	a_no_trigger_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && res_q.result_valid) |-> (res_q.trigger_pins == '0))
		else $error("trigger driven on a measurement tick");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !res_q.result_valid) |->
		(res_q.distance_cm == '0 && res_q.measured_sensor == '0))
		else $error("measurement fields set without a result");

	a_near_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && res_q.result_valid) |->
		(res_q.near_flag == (res_q.distance_cm <= cfg_q.near_threshold_cm)))
		else $error("near flag disagrees with distance");

endmodule
